FILE: sv/vrp_pkg.sv
// Shared widths, register indexes and the sine table for vertex_rotate_project.
// No dependencies; imported by vrp_rot, vrp_div and the top level.
package vrp_pkg;

  // field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned AngW    = 6;
  localparam int unsigned TrigW   = 11;
  localparam int unsigned RotW    = 18;  // rotated coordinate, signed
  localparam int unsigned WorldW  = 19;  // rotated plus offset, signed
  localparam int unsigned CenterW = 12;
  localparam int unsigned FocalW  = 12;
  localparam int unsigned NearW   = 16;
  localparam int unsigned ScrW    = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // perspective divide
  localparam int unsigned MagW = WorldW;          // magnitude of a world coordinate
  localparam int unsigned NumW = MagW + FocalW;   // numerator magnitude
  localparam int unsigned DenW = WorldW - 1;      // positive depth
  localparam int unsigned DivLat = NumW;          // one quotient bit per stage

  // divide by 1000: reciprocal multiply, then one correction step
  localparam int unsigned TrigScale  = 1000;
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RecipW     = 19;
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << RecipShift) / TrigScale);
  localparam int unsigned RotLat = 3;

  // input reg, two rotations, offset stage, multiply stage, divider
  localparam int unsigned PipeLat = 1 + 2 * RotLat + 2 + DivLat;

  // register indexes
  localparam logic [CfgAddrW-1:0] CfgOffsetX = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgOffsetY = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgOffsetZ = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgCenterX = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgCenterY = 3'd4;
  localparam logic [CfgAddrW-1:0] CfgFocal   = 3'd5;
  localparam logic [CfgAddrW-1:0] CfgNear    = 3'd6;

  // side information carried alongside the divider
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic vis;
  } div_side_t;

  // full-wave sine scaled by 1000, full turn in 64 steps
  localparam logic signed [TrigW-1:0] SineLut [64] = '{
    11'sd0,    11'sd98,   11'sd195,  11'sd290,  11'sd383,  11'sd471,  11'sd556,  11'sd634,
    11'sd707,  11'sd773,  11'sd831,  11'sd882,  11'sd924,  11'sd957,  11'sd981,  11'sd995,
    11'sd1000, 11'sd995,  11'sd981,  11'sd957,  11'sd924,  11'sd882,  11'sd831,  11'sd773,
    11'sd707,  11'sd634,  11'sd556,  11'sd471,  11'sd383,  11'sd290,  11'sd195,  11'sd98,
    11'sd0,    -11'sd98,  -11'sd195, -11'sd290, -11'sd383, -11'sd471, -11'sd556, -11'sd634,
    -11'sd707, -11'sd773, -11'sd831, -11'sd882, -11'sd924, -11'sd957, -11'sd981, -11'sd995,
    -11'sd1000, -11'sd995, -11'sd981, -11'sd957, -11'sd924, -11'sd882, -11'sd831, -11'sd773,
    -11'sd707, -11'sd634, -11'sd556, -11'sd471, -11'sd383, -11'sd290, -11'sd195, -11'sd98
  };

  function automatic logic signed [TrigW-1:0] sin_at(input logic [AngW-1:0] ang);
    return SineLut[ang];
  endfunction

  function automatic logic signed [TrigW-1:0] cos_at(input logic [AngW-1:0] ang);
    logic [AngW-1:0] idx;
    idx = ang + AngW'(16);
    return SineLut[idx];
  endfunction

endpackage

FILE: sv/vrp_rot.sv
// One plane rotation over three stages: p = (a*c + b*s)/1000, q = (b*c - a*s)/1000,
// truncated toward zero. Depends on vrp_pkg.
module vrp_rot (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [vrp_pkg::RotW-1:0]    a_i,
  input  logic signed [vrp_pkg::RotW-1:0]    b_i,
  input  logic signed [vrp_pkg::TrigW-1:0]   c_i,
  input  logic signed [vrp_pkg::TrigW-1:0]   s_i,
  output logic signed [vrp_pkg::RotW-1:0]    p_o,
  output logic signed [vrp_pkg::RotW-1:0]    q_o
);
  import vrp_pkg::*;

  localparam int unsigned ProdW = RotW + TrigW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned AbsW  = ProdW;
  localparam int unsigned RecW  = AbsW + RecipW;

  logic signed [ProdW-1:0] ac_q, bs_q, bc_q, as_q;
  logic signed [SumW-1:0]  sum_p, sum_q;
  logic [AbsW-1:0]         abs_p, abs_q;
  logic [RecW-1:0]         rec_p_d, rec_q_d, rec_p_q, rec_q_q;
  logic [AbsW-1:0]         mag_p_q, mag_q_q;
  logic                    neg_p_q, neg_q_q;
  logic signed [RotW-1:0]  p_d, q_d, p_q, q_q;

  // exact quotient from the reciprocal estimate, which is low by at most one
  function automatic logic signed [RotW-1:0] fix_div(input logic [RecW-1:0] rec,
                                                    input logic [AbsW-1:0] mag,
                                                    input logic neg);
    logic [RotW-1:0]  q0;
    logic [AbsW:0]    rem;
    logic [RotW-1:0]  qm;
    q0  = rec[RecipShift +: RotW];
    rem = {1'b0, mag} - ((AbsW+1)'(q0) * (AbsW+1)'(TrigScale));
    qm  = (rem >= (AbsW+1)'(TrigScale)) ? q0 + RotW'(1) : q0;
    return neg ? -$signed(qm) : $signed(qm);
  endfunction

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q <= ProdW'(a_i * c_i);
      bs_q <= ProdW'(b_i * s_i);
      bc_q <= ProdW'(b_i * c_i);
      as_q <= ProdW'(a_i * s_i);
    end
  end

  // stage 2: sums, magnitudes and reciprocal multiply
  always_comb begin
    sum_p   = SumW'(ac_q) + SumW'(bs_q);
    sum_q   = SumW'(bc_q) - SumW'(as_q);
    abs_p   = sum_p[SumW-1] ? AbsW'(-sum_p) : AbsW'(sum_p);
    abs_q   = sum_q[SumW-1] ? AbsW'(-sum_q) : AbsW'(sum_q);
    rec_p_d = RecW'(abs_p) * RecW'(Recip);
    rec_q_d = RecW'(abs_q) * RecW'(Recip);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rec_p_q <= rec_p_d;
      rec_q_q <= rec_q_d;
      mag_p_q <= abs_p;
      mag_q_q <= abs_q;
      neg_p_q <= sum_p[SumW-1];
      neg_q_q <= sum_q[SumW-1];
    end
  end

  // stage 3: correction and sign
  assign p_d = fix_div(rec_p_q, mag_p_q, neg_p_q);
  assign q_d = fix_div(rec_q_q, mag_q_q, neg_q_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      q_q <= q_d;
    end
  end

  assign p_o = p_q;
  assign q_o = q_q;

endmodule

FILE: sv/vrp_div.sv
// Pipelined restoring divider, two numerators over one divisor, one quotient bit
// per stage. Side information travels with the data. Depends on vrp_pkg.
module vrp_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [vrp_pkg::NumW-1:0]      num_x_i,
  input  logic [vrp_pkg::NumW-1:0]      num_y_i,
  input  logic [vrp_pkg::DenW-1:0]      den_i,
  input  vrp_pkg::div_side_t            side_i,
  output logic [vrp_pkg::NumW-1:0]      quot_x_o,
  output logic [vrp_pkg::NumW-1:0]      quot_y_o,
  output vrp_pkg::div_side_t            side_o
);
  import vrp_pkg::*;

  // shift registers hold remaining numerator bits above, quotient bits below
  logic [NumW-1:0] shx_q  [DivLat];
  logic [NumW-1:0] shy_q  [DivLat];
  logic [DenW-1:0] remx_q [DivLat];
  logic [DenW-1:0] remy_q [DivLat];
  logic [DenW-1:0] den_q  [DivLat];
  div_side_t       side_q [DivLat];

  for (genvar i = 0; i < DivLat; i++) begin : g_stage
    logic [NumW-1:0] shx_in, shy_in;
    logic [DenW-1:0] remx_in, remy_in, den_in;
    div_side_t       side_in;
    logic [DenW:0]   trial_x, trial_y;
    logic            ge_x, ge_y;

    if (i == 0) begin : g_first
      assign shx_in  = num_x_i;
      assign shy_in  = num_y_i;
      assign remx_in = '0;
      assign remy_in = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign shx_in  = shx_q[i-1];
      assign shy_in  = shy_q[i-1];
      assign remx_in = remx_q[i-1];
      assign remy_in = remy_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    // trial subtract
    assign trial_x = {remx_in, shx_in[NumW-1]};
    assign trial_y = {remy_in, shy_in[NumW-1]};
    assign ge_x    = trial_x >= {1'b0, den_in};
    assign ge_y    = trial_y >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        remx_q[i] <= ge_x ? DenW'(trial_x - {1'b0, den_in}) : DenW'(trial_x);
        remy_q[i] <= ge_y ? DenW'(trial_y - {1'b0, den_in}) : DenW'(trial_y);
        shx_q[i]  <= {shx_in[NumW-2:0], ge_x};
        shy_q[i]  <= {shy_in[NumW-2:0], ge_y};
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign quot_x_o = shx_q[DivLat-1];
  assign quot_y_o = shy_q[DivLat-1];
  assign side_o   = side_q[DivLat-1];

endmodule

FILE: sv/vertex_rotate_project.sv
// vertex_rotate_project: rotates a vertex about Y then X and projects it to the screen.
// Depends on vrp_pkg, vrp_rot and vrp_div.
//
// Usage:
//   Vertices enter on the s_axis stream (x, y, z, yaw, pitch) and one screen
//   point leaves on the m_axis stream for each. The user must set registers
//   through the plain write port (cfg_we_i, cfg_addr_i, cfg_data_i) only while
//   the block is idle (not enforced by the block); an index beyond the list is ignored.
//   Throughput: one item per cycle with no gaps while the receiver does not stall.
//   Path: 41 register stages from acceptance to the result standing on m_axis,
//   the first loaded at acceptance:
//   input register, two rotation units of three stages each, offset stage,
//   perspective multiply stage, a 31-stage divider (one quotient bit per stage,
//   set by the width of coordinate times focal length) and the output register.
//   Reset clears all valid bits and loads the register defaults (offset_z 1500,
//   centre 320/240, focal length 500, near limit 100).
//   When the receiver stalls, the whole pipeline holds; s_axis_tready falls only
//   while a result waits in the output register and is not being taken, and
//   nothing is lost or repeated.
//   Points behind the near limit come out with visible 0 and zero coordinates.
module vertex_rotate_project (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: vert_x[15:0], vert_y[31:16], vert_z[47:32], yaw_angle[53:48],
  //        pitch_angle[59:54], zero fill above
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  // tdata: screen_x[15:0], screen_y[31:16], visible[32], zero fill above
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [vrp_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [vrp_pkg::CfgDataW-1:0]       cfg_data_i
);
  import vrp_pkg::*;

  // configuration registers
  logic signed [CoordW-1:0] off_x_q, off_y_q, off_z_q;
  logic [CenterW-1:0]       ctr_x_q, ctr_y_q;
  logic [FocalW-1:0]        focal_q;
  logic [NearW-1:0]         near_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= 16'sd1500;
      ctr_x_q <= 12'd320;
      ctr_y_q <= 12'd240;
      focal_q <= 12'd500;
      near_q  <= 16'd100;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgOffsetX: off_x_q <= cfg_data_i;
        CfgOffsetY: off_y_q <= cfg_data_i;
        CfgOffsetZ: off_z_q <= cfg_data_i;
        CfgCenterX: ctr_x_q <= cfg_data_i[CenterW-1:0];
        CfgCenterY: ctr_y_q <= cfg_data_i[CenterW-1:0];
        CfgFocal:   focal_q <= cfg_data_i[FocalW-1:0];
        CfgNear:    near_q  <= cfg_data_i[NearW-1:0];
        default: ;
      endcase
    end
  end

  // global advance: move when the output register is free or being emptied
  logic              en;
  logic              out_valid_q;
  logic [PipeLat-1:0] vld_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[PipeLat-2:0], s_axis_tvalid};
      out_valid_q <= vld_q[PipeLat-1];
    end
  end

  // input stage: unpack and look up sine and cosine
  logic signed [RotW-1:0]  px_q, py_q, pz_q;
  logic signed [TrigW-1:0] cy_q, sy_q, cp_q, sp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= RotW'($signed(s_axis_tdata[15:0]));
      py_q <= RotW'($signed(s_axis_tdata[31:16]));
      pz_q <= RotW'($signed(s_axis_tdata[47:32]));
      sy_q <= sin_at(s_axis_tdata[53:48]);
      cy_q <= cos_at(s_axis_tdata[53:48]);
      sp_q <= sin_at(s_axis_tdata[59:54]);
      cp_q <= cos_at(s_axis_tdata[59:54]);
    end
  end

  // rotation about Y: rx, rz
  logic signed [RotW-1:0] rx, rz;

  vrp_rot u_rot_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (px_q),
    .b_i   (pz_q),
    .c_i   (cy_q),
    .s_i   (sy_q),
    .p_o   (rx),
    .q_o   (rz)
  );

  // delay y and pitch terms alongside the first rotation, and rx alongside the second
  logic signed [RotW-1:0]  py_dly_q [RotLat];
  logic signed [TrigW-1:0] cp_dly_q [RotLat];
  logic signed [TrigW-1:0] sp_dly_q [RotLat];
  logic signed [RotW-1:0]  rx_dly_q [RotLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      py_dly_q[0] <= py_q;
      cp_dly_q[0] <= cp_q;
      sp_dly_q[0] <= sp_q;
      rx_dly_q[0] <= rx;
      for (int i = 1; i < RotLat; i++) begin
        py_dly_q[i] <= py_dly_q[i-1];
        cp_dly_q[i] <= cp_dly_q[i-1];
        sp_dly_q[i] <= sp_dly_q[i-1];
        rx_dly_q[i] <= rx_dly_q[i-1];
      end
    end
  end

  // rotation about X: rz2 = (rz*cp + py*sp)/1000, ry = (py*cp - rz*sp)/1000
  logic signed [RotW-1:0] rz2, ry;

  vrp_rot u_rot_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (rz),
    .b_i   (py_dly_q[RotLat-1]),
    .c_i   (cp_dly_q[RotLat-1]),
    .s_i   (sp_dly_q[RotLat-1]),
    .p_o   (rz2),
    .q_o   (ry)
  );

  // offset stage and near test
  logic signed [WorldW-1:0] wx_d, wy_d, wz_d;
  logic signed [WorldW-1:0] wx_q, wy_q, wz_q;
  logic [NearW-1:0]         limit;
  logic                     vis_d, vis_q;

  always_comb begin
    wx_d  = WorldW'(rx_dly_q[RotLat-1]) + WorldW'(off_x_q);
    wy_d  = WorldW'(ry) + WorldW'(off_y_q);
    wz_d  = WorldW'(rz2) + WorldW'(off_z_q);
    limit = (near_q == '0) ? NearW'(1) : near_q;
    vis_d = wz_d >= $signed(WorldW'(limit));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q  <= wx_d;
      wy_q  <= wy_d;
      wz_q  <= wz_d;
      vis_q <= vis_d;
    end
  end

  // perspective multiply on magnitudes
  logic [MagW-1:0]  mag_x, mag_y;
  logic [NumW-1:0]  num_x_q, num_y_q;
  logic [DenW-1:0]  den_q;
  div_side_t        side_q;

  assign mag_x = wx_q[WorldW-1] ? MagW'(-wx_q) : MagW'(wx_q);
  assign mag_y = wy_q[WorldW-1] ? MagW'(-wy_q) : MagW'(wy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_x_q      <= NumW'(mag_x) * NumW'(focal_q);
      num_y_q      <= NumW'(mag_y) * NumW'(focal_q);
      den_q        <= wz_q[DenW-1:0];
      side_q.neg_x <= wx_q[WorldW-1];
      side_q.neg_y <= wy_q[WorldW-1];
      side_q.vis   <= vis_q;
    end
  end

  // divide by depth
  logic [NumW-1:0] quot_x, quot_y;
  div_side_t       side_out;

  vrp_div u_div (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_x_i  (num_x_q),
    .num_y_i  (num_y_q),
    .den_i    (den_q),
    .side_i   (side_q),
    .quot_x_o (quot_x),
    .quot_y_o (quot_y),
    .side_o   (side_out)
  );

  // centre, saturate and register the result
  localparam int unsigned QsW = NumW + 1;
  localparam int unsigned ScW = QsW + 1;
  localparam logic signed [ScW-1:0] SatHi = ScW'(32767);
  localparam logic signed [ScW-1:0] SatLo = -ScW'(32768);

  logic signed [QsW-1:0]  qs_x, qs_y;
  logic signed [ScW-1:0]  sc_x, sc_y;
  logic signed [ScrW-1:0] scr_x_d, scr_y_d, scr_x_q, scr_y_q;
  logic                   vis_out_q;

  always_comb begin
    qs_x = side_out.neg_x ? -$signed({1'b0, quot_x}) : $signed({1'b0, quot_x});
    qs_y = side_out.neg_y ? -$signed({1'b0, quot_y}) : $signed({1'b0, quot_y});
    sc_x = $signed(ScW'(ctr_x_q)) + ScW'(qs_x);
    sc_y = $signed(ScW'(ctr_y_q)) - ScW'(qs_y);
    if (!side_out.vis) begin
      scr_x_d = '0;
      scr_y_d = '0;
    end else begin
      scr_x_d = (sc_x > SatHi) ? ScrW'(SatHi) : (sc_x < SatLo) ? ScrW'(SatLo) : ScrW'(sc_x);
      scr_y_d = (sc_y > SatHi) ? ScrW'(SatHi) : (sc_y < SatLo) ? ScrW'(SatLo) : ScrW'(sc_y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      scr_x_q   <= scr_x_d;
      scr_y_q   <= scr_y_d;
      vis_out_q <= side_out.vis;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, vis_out_q, scr_y_q, scr_x_q};

  // a hidden point carries zero coordinates
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("hidden point with non-zero coordinates");

  // a stalled pipeline keeps every valid bit where it is
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(out_valid_q))
    else $error("pipeline moved while stalled");

  // the last stage's valid reaches the output on any advance
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[PipeLat-1] |=> out_valid_q)
    else $error("result lost at output register");

endmodule
